FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hw/rtl/hpc_pkg.sv
package hpc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int NWORDS       = 10;
  localparam int MAX_RES      = 32;
  localparam int WORD_W       = 32;
  localparam int DIST_W       = 34;
  localparam int T_W          = 17;
  localparam int DIV_STEPS    = T_W;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int RES_W        = $clog2(MAX_RES + 1);
  localparam int K_W          = $clog2(DIV_STEPS);
  localparam int LIDX_W       = $clog2(NWORDS);
  localparam int PLANE_W      = 3;

  localparam logic [T_W-1:0] T_ONE = T_W'(1 << 16);

  // plane codes
  localparam logic [PLANE_W-1:0] PL_W_EPS = 3'd0;
  localparam logic [PLANE_W-1:0] PL_X_POS = 3'd1;
  localparam logic [PLANE_W-1:0] PL_X_NEG = 3'd2;
  localparam logic [PLANE_W-1:0] PL_Y_POS = 3'd3;
  localparam logic [PLANE_W-1:0] PL_Y_NEG = 3'd4;
  localparam logic [PLANE_W-1:0] PL_Z_POS = 3'd5;
  localparam logic [PLANE_W-1:0] PL_Z_NEG = 3'd6;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NWORDS-1:0] vtx_t;

  typedef enum logic {SRC_LERP, SRC_CUR} src_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic              plane_ld;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              load_prev;
    logic              load_cur;
    logic              shift;
    logic              div_init;
    logic              div_step;
    logic              mul_en;
    logic [LIDX_W-1:0] widx;
    logic              produce;
    src_t              src;
    logic              flush;
  } dp_cmd_t;

  typedef struct packed {
    logic crossing;
    logic cur_in;
  } dp_stat_t;

endpackage

FILE: hw/rtl/hpc_datapath.sv
module hpc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpc_pkg::dp_cmd_t                 cmd,
  input  hpc_pkg::vtx_t                    in_vtx,
  input  logic [hpc_pkg::PLANE_W-1:0]      in_plane,
  output hpc_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  output hpc_pkg::vtx_t                    out_vtx,
  output logic                             out_status,
  output logic                             out_last
);
  import hpc_pkg::*;

  localparam int REM_W  = DIST_W + 2;
  localparam int DIFF_W = WORD_W + 1;
  localparam int PROD_W = DIFF_W + T_W + 1;

  vtx_t mem [MAX_VERTICES];
  vtx_t rdata_r;
  logic [PLANE_W-1:0] plane_r;

  vtx_t prev_r, cur_r, res_r, pend_r;
  logic signed [DIST_W-1:0] dprev_r, dcur_r, rd_dist;
  logic [REM_W-1:0] rem_r, dvs_r;
  logic [T_W-1:0] q_r, t_q;
  logic signed [DIST_W:0] den;
  logic [DIST_W-1:0] an;
  logic [DIST_W:0] ad;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  word_t a_r;
  logic [LIDX_W-1:0] midx_r;
  logic mul_v_r, pend_v_r;
  logic out_valid_r, out_status_r, out_last_r;
  vtx_t out_vtx_r;

  function automatic logic signed [DIST_W-1:0] dist_f(vtx_t v, logic [PLANE_W-1:0] p);
    logic signed [DIST_W-1:0] x, y, z, w;
    x = DIST_W'(signed'(v[0]));
    y = DIST_W'(signed'(v[1]));
    z = DIST_W'(signed'(v[2]));
    w = DIST_W'(signed'(v[3]));
    case (p)
      PL_W_EPS: dist_f = w - DIST_W'(1);
      PL_X_POS: dist_f = w - x;
      PL_X_NEG: dist_f = w + x;
      PL_Y_POS: dist_f = w - y;
      PL_Y_NEG: dist_f = w + y;
      PL_Z_POS: dist_f = w - z;
      PL_Z_NEG: dist_f = w + z;
      default:  dist_f = -DIST_W'(1);
    endcase
  endfunction

  // vertex store, one row per vertex
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.waddr] <= in_vtx;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.raddr];
    end
  end

  assign rd_dist = dist_f(rdata_r, plane_r);

  assign stat.crossing = dprev_r[DIST_W-1] != dcur_r[DIST_W-1];
  assign stat.cur_in   = !dcur_r[DIST_W-1];

  assign an  = dprev_r[DIST_W-1] ? DIST_W'(-dprev_r) : DIST_W'(dprev_r);
  assign den = (DIST_W+1)'(dprev_r) - (DIST_W+1)'(dcur_r);
  assign ad  = den[DIST_W] ? (DIST_W+1)'(-den) : (DIST_W+1)'(den);
  assign t_q = (q_r > T_ONE) ? T_ONE : q_r;

  assign diff = DIFF_W'(signed'(cur_r[cmd.widx])) - DIFF_W'(signed'(prev_r[cmd.widx]));
  assign prod_nxt = diff * signed'({1'b0, t_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r     <= '0;
      mul_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.plane_ld) begin
        plane_r <= in_plane;
      end
      if (cmd.load_prev) begin
        prev_r  <= rdata_r;
        dprev_r <= rd_dist;
      end
      if (cmd.load_cur) begin
        cur_r  <= rdata_r;
        dcur_r <= rd_dist;
      end
      if (cmd.shift) begin
        prev_r  <= cur_r;
        dprev_r <= dcur_r;
      end
      // restoring divide, one quotient bit a cycle while div_step is set
      if (cmd.div_init) begin
        rem_r <= REM_W'(an);
        dvs_r <= REM_W'(ad);
        q_r   <= '0;
      end else if (cmd.div_step) begin
        if (rem_r >= dvs_r) begin
          q_r   <= {q_r[T_W-2:0], 1'b1};
          rem_r <= REM_W'((rem_r - dvs_r) << 1);
        end else begin
          q_r   <= {q_r[T_W-2:0], 1'b0};
          rem_r <= REM_W'(rem_r << 1);
        end
      end
      // interpolation: multiply stage, then add stage
      mul_v_r <= cmd.mul_en;
      if (cmd.mul_en) begin
        prod_r <= prod_nxt;
        a_r    <= prev_r[cmd.widx];
        midx_r <= cmd.widx;
      end
      if (mul_v_r) begin
        res_r[midx_r] <= a_r + prod_r[WORD_W+15:16];
      end
      // one-deep hold so the final item can carry last
      out_valid_r <= 1'b0;
      if (cmd.produce) begin
        pend_r   <= (cmd.src == SRC_LERP) ? res_r : cur_r;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_valid_r  <= 1'b1;
          out_vtx_r    <= pend_r;
          out_status_r <= 1'b0;
          out_last_r   <= 1'b0;
        end
      end else if (cmd.flush) begin
        pend_v_r    <= 1'b0;
        out_valid_r <= 1'b1;
        out_last_r  <= 1'b1;
        if (pend_v_r) begin
          out_vtx_r    <= pend_r;
          out_status_r <= 1'b0;
        end else begin
          out_vtx_r    <= '0;
          out_status_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vtx    = out_vtx_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

FILE: hw/rtl/hpc_ctrl.sv
module hpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_last_vertex,
  input  hpc_pkg::dp_stat_t stat,
  output logic              busy,
  output hpc_pkg::dp_cmd_t  cmd
);
  import hpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDP, S_LDP, S_LDC, S_CHK, S_DIV, S_LERP,
    S_EMIT_X, S_EMIT_C, S_NEXT, S_FLUSH
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r, i_r, cnt_m1, i_p1;
  logic [K_W-1:0] k_r;
  logic [RES_W-1:0] n_r;
  logic accept, has_room, can_emit;

  assign accept   = start && (state_r == S_IDLE);
  assign has_room = cnt_r < CNT_W'(MAX_VERTICES);
  assign can_emit = n_r < RES_W'(MAX_RES);
  assign cnt_m1   = cnt_r - 1'b1;
  assign i_p1     = i_r + 1'b1;
  assign busy     = state_r != S_IDLE;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.wr_en    = accept && has_room;
        cmd.waddr    = cnt_r[ADDR_W-1:0];
        cmd.plane_ld = accept && (cnt_r == '0);
      end
      S_RDP: begin
        cmd.rd_en = 1'b1;
        cmd.raddr = cnt_m1[ADDR_W-1:0];
      end
      S_LDP: begin
        cmd.load_prev = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.raddr     = i_r[ADDR_W-1:0];
      end
      S_LDC:  cmd.load_cur = 1'b1;
      S_CHK:  cmd.div_init = stat.crossing;
      S_DIV:  cmd.div_step = 1'b1;
      S_LERP: begin
        cmd.mul_en = k_r < K_W'(NWORDS);
        cmd.widx   = k_r[LIDX_W-1:0];
      end
      S_EMIT_X: begin
        cmd.produce = can_emit;
        cmd.src     = SRC_LERP;
      end
      S_EMIT_C: begin
        cmd.produce = stat.cur_in && can_emit;
        cmd.src     = SRC_CUR;
      end
      S_NEXT: begin
        cmd.shift = 1'b1;
        cmd.rd_en = i_p1 != cnt_r;
        cmd.raddr = i_p1[ADDR_W-1:0];
      end
      S_FLUSH: cmd.flush = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            i_r <= '0;
            n_r <= '0;
            if (has_room) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_last_vertex) begin
              if ((has_room ? cnt_r + 1'b1 : cnt_r) >= CNT_W'(3)) begin
                state_r <= S_RDP;
              end else begin
                state_r <= S_FLUSH;
              end
            end
          end
        end
        S_RDP: state_r <= S_LDP;
        S_LDP: state_r <= S_LDC;
        S_LDC: state_r <= S_CHK;
        S_CHK: begin
          k_r     <= '0;
          state_r <= stat.crossing ? S_DIV : S_EMIT_C;
        end
        S_DIV: begin
          if (k_r == K_W'(DIV_STEPS - 1)) begin
            k_r     <= '0;
            state_r <= S_LERP;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_LERP: begin
          if (k_r == K_W'(NWORDS)) begin
            state_r <= S_EMIT_X;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_EMIT_X: begin
          if (cmd.produce) begin
            n_r <= n_r + 1'b1;
          end
          state_r <= S_EMIT_C;
        end
        S_EMIT_C: begin
          if (cmd.produce) begin
            n_r <= n_r + 1'b1;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          i_r     <= i_p1;
          state_r <= (i_p1 == cnt_r) ? S_FLUSH : S_LDC;
        end
        S_FLUSH: begin
          cnt_r   <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/homogeneous_plane_polygon_clipper_core.sv
// single-plane polygon clipper in homogeneous clip space. vertices are loaded
// with start while busy is low, one per cycle, and are stored in a row-wide
// vertex memory; the plane code is taken from the first vertex. the vertex
// marked last raises busy and starts the edge walk: each edge takes one
// memory read and a distance check, and each crossing adds the 17-step
// one-bit-per-cycle ratio divider and the shared multiplier that
// interpolates the ten words one after another. results leave on out_valid
// for one cycle each, the receiver cannot stall, and the final one carries
// out_last_out. fewer than three vertices, or nothing inside, yield one item
// with out_status set and all words zero. vertices beyond capacity are dropped
`include "assert_macros.svh"
module homogeneous_plane_polygon_clipper_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_clip_x,
  input  logic signed [31:0]              in_clip_y,
  input  logic signed [31:0]              in_clip_z,
  input  logic signed [31:0]              in_clip_w,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic signed [31:0]              in_pos_z,
  input  logic signed [31:0]              in_norm_x,
  input  logic signed [31:0]              in_norm_y,
  input  logic signed [31:0]              in_norm_z,
  input  logic [hpc_pkg::PLANE_W-1:0]     in_plane_sel,
  input  logic                            in_last_vertex,
  output logic                            out_valid,
  output logic signed [31:0]              out_clip_x,
  output logic signed [31:0]              out_clip_y,
  output logic signed [31:0]              out_clip_z,
  output logic signed [31:0]              out_clip_w,
  output logic signed [31:0]              out_pos_x,
  output logic signed [31:0]              out_pos_y,
  output logic signed [31:0]              out_pos_z,
  output logic signed [31:0]              out_norm_x,
  output logic signed [31:0]              out_norm_y,
  output logic signed [31:0]              out_norm_z,
  output logic                            out_status,
  output logic                            out_last_out
);
  import hpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  vtx_t     in_vtx, out_vtx;

  // word 0 is clip x, word 9 is normal z
  assign in_vtx = {in_norm_z, in_norm_y, in_norm_x, in_pos_z, in_pos_y, in_pos_x,
                   in_clip_w, in_clip_z, in_clip_y, in_clip_x};

  // sequencer: load, edge walk, flush
  hpc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_last_vertex (in_last_vertex),
    .stat           (stat),
    .busy           (busy),
    .cmd            (cmd)
  );

  // vertex memory, distances, divider, interpolator, output hold
  hpc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_vtx     (in_vtx),
    .in_plane   (in_plane_sel),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_vtx    (out_vtx),
    .out_status (out_status),
    .out_last   (out_last_out)
  );

  assign out_clip_x = out_vtx[0];
  assign out_clip_y = out_vtx[1];
  assign out_clip_z = out_vtx[2];
  assign out_clip_w = out_vtx[3];
  assign out_pos_x  = out_vtx[4];
  assign out_pos_y  = out_vtx[5];
  assign out_pos_z  = out_vtx[6];
  assign out_norm_x = out_vtx[7];
  assign out_norm_y = out_vtx[8];
  assign out_norm_z = out_vtx[9];

  // the empty marker is always the only, and so the final, item
  `AST_IMPL(a_empty_last, out_valid && out_status, out_last_out)
  // the empty marker carries zero words
  `AST_IMPL(a_empty_zero, out_valid && out_status, out_clip_w == 32'sd0 && out_norm_z == 32'sd0)
  // a last vertex always starts a walk or flush
  `AST_NEXT(a_last_busy, start && !busy && in_last_vertex, busy)

endmodule
